// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the filter RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DAFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition must never be true outside reset.
`define DAFR_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ----- rtl/core/dafr_pkg.sv -----
// Types, codes and helpers for the distinct/repeat filter.
// No dependencies.
package dafr_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EMIT_MODE = 2'd1;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample_value;
		logic                     new_list;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] key_out;
		logic                     keep;
		logic                     set_overflow;
	} out_item_t;

	// Request into the scan engine.
	typedef struct packed {
		logic [DATA_W-1:0] key;
		logic              new_list;
	} scan_req_t;

	// Outcome of one scan.
	typedef struct packed {
		logic [DATA_W-1:0] key;
		logic              found;
		logic              overflow;
	} scan_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} scan_state_t;

	// Magnitude, saturating the most negative value.
	function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] r;
		if (v == {1'b1, {(DATA_W-1){1'b0}}}) begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (v[DATA_W-1]) begin
			r = ~v + {{(DATA_W-1){1'b0}}, 1'b1};
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/dafr_mem.sv -----
// Key store: single write port, single read port, registered read data.
// Uses dafr_pkg for the data width.
module dafr_mem #(
	parameter int unsigned DEPTH  = 64,
	parameter int unsigned ADDR_W = 6
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [ADDR_W-1:0]         wr_addr,
	input  logic [dafr_pkg::DATA_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [ADDR_W-1:0]         rd_addr,
	output logic [dafr_pkg::DATA_W-1:0] rd_data
);
	import dafr_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/dafr_scan.sv -----
// Scan engine: seen-key count, linear search of the key store, append.
// Uses dafr_pkg, dafr_mem and assert_macros.svh.
`include "assert_macros.svh"

module dafr_scan #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  dafr_pkg::scan_req_t req,
	output logic                res_valid,
	input  logic                res_ready,
	output dafr_pkg::scan_res_t res
);
	import dafr_pkg::*;

	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

	scan_state_t       state_q, state_d;
	logic [DATA_W-1:0] key_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              cmp_vld_s1;
	logic              found_q;
	logic [DATA_W-1:0] rd_data;
	logic              hit, issue, scan_end, full;
	logic              rd_en, wr_en;

	dafr_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (key_q),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	assign full     = (count_q == CNT_W'(DEPTH));
	assign hit      = (state_q == ST_SCAN) && cmp_vld_s1 && (rd_data == key_q);
	assign issue    = (state_q == ST_SCAN) && (rd_idx_q < count_q) && !hit;
	assign scan_end = (state_q == ST_SCAN) && !issue;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (req_valid) state_d = ST_SCAN;
			ST_SCAN: if (scan_end)  state_d = ST_DONE;
			ST_DONE: if (res_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready    = (state_q == ST_IDLE);
		res_valid    = (state_q == ST_DONE);
		rd_en        = issue;
		wr_en        = (state_q == ST_DONE) && res_ready && !found_q && !full;
		res.key      = key_q;
		res.found    = found_q;
		res.overflow = !found_q && full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= issue;
			if (req_valid && req_ready) begin
				rd_idx_q <= '0;
				if (req.new_list) begin
					count_q <= '0;
				end
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (scan_end) begin
				found_q <= hit;
			end
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			key_q <= req.key;
		end
	end

	`DAFR_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "seen count beyond set depth")
	`DAFR_ASSERT(a_read_in_set, rd_en |-> rd_idx_q < count_q, "read beyond stored keys")
	`DAFR_ASSERT(a_append_grows, wr_en |=> count_q == $past(count_q) + CNT_W'(1), "append lost")
	`DAFR_ASSERT_NEVER(a_no_rw_overlap, rd_en && wr_en, "read and write in one cycle")

endmodule

// ----- rtl/core/distinct_and_repeat_filter.sv -----
// Path: an accepted request is scanned in ST_SCAN, which compares stored keys in order (at most the
// keys stored in the set; a match ends the scan early), then is held in ST_DONE until taken.
// One request at a time: the next is accepted only once the result has left ST_DONE; the
// key store's single read port, one key per cycle, sets the scan length.
// A finished result waits in the output register while the next request is scanned.
// Reset (arst_n, async, active low): empty set, key_mode/emit_mode 0, no result held.
`include "assert_macros.svh"

module distinct_and_repeat_filter #(
	parameter int unsigned SET_DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [dafr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dafr_pkg::CFG_DAT_W-1:0]      cfg_wdata,
	// request channel
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  dafr_pkg::in_item_t                  sample,
	// result channel
	output logic                                result_valid,
	input  logic                                result_ready,
	output dafr_pkg::out_item_t                 result
);
	import dafr_pkg::*;

	logic      key_mode_q, emit_mode_q;
	scan_req_t scan_req;
	scan_res_t scan_res;
	logic      res_valid, res_ready;
	logic      result_valid_q;
	out_item_t result_q;

	// Configuration registers; indexes past the list drop silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mode_q  <= 1'b0;
			emit_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_MODE:  key_mode_q  <= cfg_wdata[0];
				CFG_EMIT_MODE: emit_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Form the key: raw value, or saturating magnitude.
	always_comb begin
		scan_req.key      = key_mode_q ? magnitude(sample.sample_value) : sample.sample_value;
		scan_req.new_list = sample.new_list;
	end

	dafr_scan #(
		.DEPTH (SET_DEPTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (sample_valid),
		.req_ready (sample_ready),
		.req       (scan_req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (scan_res)
	);

	// Output register: take a new result when empty or being drained.
	assign res_ready = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_ready) begin
			result_valid_q <= res_valid;
		end
	end

	// Apply the emit filter while loading the result.
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			result_q.key_out      <= scan_res.key;
			result_q.keep         <= emit_mode_q ? scan_res.found : !scan_res.found;
			result_q.set_overflow <= scan_res.overflow;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`DAFR_ASSERT(a_one_in_flight, sample_valid && sample_ready |=> !sample_ready, "overlap")

endmodule
